// ===== hdl/mrm_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the region map.
package mrm_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int PAGE_SHIFT_DEF  = 12;
  localparam int MAX_RESULTS     = 32;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] FUNC_INSTALL    = 2'd0;
  localparam logic [1:0] FUNC_UNPRESERVE = 2'd1;
  localparam logic [1:0] FUNC_READ       = 2'd2;
  localparam logic [1:0] FUNC_UNUSED     = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [3:0] RTYPE_UNDEF     = 4'd0;
  localparam logic [3:0] RTYPE_PRESERVE  = 4'd1;
  localparam logic [3:0] RTYPE_RAM       = 4'd2;
  localparam logic [3:0] RTYPE_ALLOCATED = 4'd3;
  localparam logic [3:0] RTYPE_BADRAM    = 4'd8;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROBE,
    OP_READ,
    OP_SPLIT_BASE,
    OP_SPLIT_END,
    OP_RAISE,
    OP_MERGE,
    OP_REPLY,
    OP_COUNT,
    OP_REWIND,
    OP_SCAN,
    OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       empty_len;
    logic       full;
    logic       need_base;
    logic       need_end;
    logic       merge_done;
    logic       scan_end;
  } dp_stat_t;

endpackage

// ===== hdl/mrm_ctrl.sv =====
// Sequencer for the region map: walks each transaction through datapath operations.
module mrm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mrm_pkg::dp_stat_t stat,
  output mrm_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_DECIDE, S_SPLIT_B, S_SPLIT_E, S_RAISE, S_MERGE,
    S_REPLY, S_COUNT, S_REWIND, S_SCAN, S_FLUSH, S_UMERGE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] rstat_r, rstat_nxt;
  logic       busy_r;

  always_comb begin
    state_nxt  = state_r;
    rstat_nxt  = rstat_r;
    cmd.op     = mrm_pkg::OP_NONE;
    cmd.status = rstat_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = mrm_pkg::OP_LOAD;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.op    = mrm_pkg::OP_PROBE;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.func == mrm_pkg::FUNC_INSTALL) begin
          if (stat.empty_len) begin
            rstat_nxt = mrm_pkg::ST_EMPTY;
            state_nxt = S_REPLY;
          end else if (stat.full) begin
            rstat_nxt = mrm_pkg::ST_FULL;
            state_nxt = S_REPLY;
          end else begin
            state_nxt = S_SPLIT_B;
          end
        end else if (stat.func == mrm_pkg::FUNC_UNPRESERVE) begin
          state_nxt = S_COUNT;
        end else if (stat.func == mrm_pkg::FUNC_READ) begin
          cmd.op    = mrm_pkg::OP_READ;
          state_nxt = S_IDLE;
        end else begin
          rstat_nxt = mrm_pkg::ST_OK;
          state_nxt = S_REPLY;
        end
      end
      S_SPLIT_B: begin
        if (stat.need_base) cmd.op = mrm_pkg::OP_SPLIT_BASE;
        state_nxt = S_SPLIT_E;
      end
      S_SPLIT_E: begin
        if (stat.need_end) cmd.op = mrm_pkg::OP_SPLIT_END;
        state_nxt = S_RAISE;
      end
      S_RAISE: begin
        cmd.op    = mrm_pkg::OP_RAISE;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.op = mrm_pkg::OP_MERGE;
        if (stat.merge_done) begin
          rstat_nxt = mrm_pkg::ST_OK;
          state_nxt = S_REPLY;
        end
      end
      S_REPLY: begin
        cmd.op    = mrm_pkg::OP_REPLY;
        state_nxt = S_IDLE;
      end
      S_COUNT: begin
        cmd.op = mrm_pkg::OP_COUNT;
        if (stat.scan_end) state_nxt = S_REWIND;
      end
      S_REWIND: begin
        cmd.op    = mrm_pkg::OP_REWIND;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = mrm_pkg::OP_SCAN;
        if (stat.scan_end) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.op    = mrm_pkg::OP_FLUSH;
        state_nxt = S_UMERGE;
      end
      S_UMERGE: begin
        cmd.op = mrm_pkg::OP_MERGE;
        if (stat.merge_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rstat_r <= mrm_pkg::ST_OK;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rstat_r <= rstat_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== hdl/mrm_dp.sv =====
// Region table, split/raise/merge logic, page scan and result registers.
module mrm_dp #(
  parameter int TABLE_DEPTH = mrm_pkg::TABLE_DEPTH_DEF,
  parameter int PAGE_SHIFT  = mrm_pkg::PAGE_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mrm_pkg::dp_cmd_t  cmd,
  output mrm_pkg::dp_stat_t stat,
  input  logic [1:0]        in_func,
  input  logic [63:0]       in_base,
  input  logic [63:0]       in_length,
  input  logic [3:0]        in_region_type,
  input  logic [4:0]        in_index,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [63:0]       out_entry_addr,
  output logic [3:0]        out_entry_type,
  output logic [5:0]        out_entry_count,
  output logic [51:0]       out_free_page,
  output logic [52:0]       out_free_pages,
  output logic              out_last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = CW + 5;
  localparam int RW = mrm_pkg::RES_CNT_W;
  localparam logic [63:0] LOWMASK = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [64:0] TOP_PAGE = 65'd1 << (64 - PAGE_SHIFT);

  logic [63:0] start_r [TABLE_DEPTH];
  logic [3:0]  kind_r  [TABLE_DEPTH];
  logic [63:0] start_nxt [TABLE_DEPTH];
  logic [3:0]  kind_nxt  [TABLE_DEPTH];
  logic [CW-1:0] count_r, count_nxt;

  // transaction registers
  logic [1:0]  func_r;
  logic [63:0] base_r, end_r;
  logic        wrap_r, zero_r;
  logic [3:0]  type_r;
  logic [4:0]  idx_r;
  logic        need_b_r, need_e_r;

  // scan state
  logic [CW-1:0] ptr_r;
  logic [CW-1:0] fcount_r;
  logic [3:0]    prev_conv_r;
  logic          prev_pres_r;
  logic [64:0]   prev_first_r;
  logic          pend_v_r;
  logic [51:0]   pend_page_r;
  logic [52:0]   pend_pages_r;
  logic [RW-1:0] ncnt_r;

  // output registers
  logic        out_valid_r, out_last_r;
  logic [1:0]  out_status_r;
  logic [63:0] out_addr_r;
  logic [3:0]  out_type_r;
  logic [5:0]  out_count_r;
  logic [51:0] out_page_r;
  logic [52:0] out_pages_r;

  logic [TABLE_DEPTH-1:0] gt, dup, from_dup, hit_b, hit_e;
  logic [63:0] split_addr;
  logic [64:0] end_sum;
  logic [XW-1:0] idx_ext;
  logic          idx_ok;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_start;
  logic [3:0]    rd_kind, rd_conv;
  logic          scan_end;
  logic [64:0]   cur_first, stop_pg, n_pages;
  logic          cand;
  logic [CW:0]   need_sum;

  assign end_sum    = {1'b0, in_base} + {1'b0, in_length};
  assign split_addr = (cmd.op == mrm_pkg::OP_SPLIT_END) ? end_r : base_r;
  assign scan_end   = (ptr_r == count_r);
  assign idx_ext    = XW'(idx_r);
  assign idx_ok     = idx_ext < XW'(count_r);
  assign rd_addr    = (cmd.op == mrm_pkg::OP_READ) ? idx_ext[AW-1:0] : ptr_r[AW-1:0];
  assign rd_start   = start_r[rd_addr];
  assign rd_kind    = kind_r[rd_addr];
  assign rd_conv    = (rd_kind == mrm_pkg::RTYPE_PRESERVE ||
                       rd_kind == mrm_pkg::RTYPE_ALLOCATED) ? mrm_pkg::RTYPE_RAM : rd_kind;

  assign cur_first = ({1'b0, rd_start} >> PAGE_SHIFT) + 65'(|(rd_start & LOWMASK));
  assign stop_pg   = scan_end ? TOP_PAGE : ({1'b0, rd_start} >> PAGE_SHIFT);
  assign n_pages   = stop_pg - prev_first_r;
  assign cand      = prev_pres_r && (stop_pg > prev_first_r) &&
                     (ncnt_r < RW'(mrm_pkg::MAX_RESULTS));
  assign need_sum  = (CW+1)'(count_r) + (CW+1)'(need_b_r) + (CW+1)'(need_e_r);

  // per-entry flags
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      gt[j]    = (CW'(j) >= count_r) || (start_r[j] > split_addr);
      hit_b[j] = (CW'(j) < count_r) && (start_r[j] == base_r);
      hit_e[j] = (CW'(j) < count_r) && (start_r[j] == end_r);
      if (j == 0) dup[j] = 1'b0;
      else        dup[j] = (CW'(j) < count_r) && (kind_r[j] == kind_r[j-1]);
    end
    from_dup[0] = dup[0];
    for (int j = 1; j < TABLE_DEPTH; j++) from_dup[j] = from_dup[j-1] | dup[j];
  end

  // table update
  always_comb begin
    start_nxt = start_r;
    kind_nxt  = kind_r;
    count_nxt = count_r;
    case (cmd.op) inside
      mrm_pkg::OP_SPLIT_BASE, mrm_pkg::OP_SPLIT_END: begin
        for (int j = 1; j < TABLE_DEPTH; j++) begin
          if (gt[j-1]) begin
            start_nxt[j] = start_r[j-1];
            kind_nxt[j]  = kind_r[j-1];
          end else if (gt[j]) begin
            start_nxt[j] = split_addr;
            kind_nxt[j]  = kind_r[j-1];
          end
        end
        count_nxt = count_r + CW'(1);
      end
      mrm_pkg::OP_RAISE: begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          if ((CW'(j) < count_r) && (start_r[j] >= base_r) &&
              (wrap_r || (start_r[j] < end_r)) && (kind_r[j] < type_r))
            kind_nxt[j] = type_r;
        end
      end
      mrm_pkg::OP_MERGE: begin
        for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
          if (from_dup[j]) begin
            start_nxt[j] = start_r[j+1];
            kind_nxt[j]  = kind_r[j+1];
          end
        end
        if (|dup) count_nxt = count_r - CW'(1);
      end
      mrm_pkg::OP_FLUSH: begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          if (kind_r[j] == mrm_pkg::RTYPE_PRESERVE ||
              kind_r[j] == mrm_pkg::RTYPE_ALLOCATED)
            kind_nxt[j] = mrm_pkg::RTYPE_RAM;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r[0] <= 64'd0;
      kind_r[0]  <= mrm_pkg::RTYPE_UNDEF;
      count_r    <= CW'(1);
    end else begin
      start_r <= start_nxt;
      kind_r  <= kind_nxt;
      count_r <= count_nxt;
    end
  end

  // transaction and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      prev_pres_r <= 1'b0;
      ptr_r       <= '0;
      ncnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (cmd.op)
        mrm_pkg::OP_LOAD: begin
          func_r      <= in_func;
          base_r      <= in_base;
          end_r       <= end_sum[63:0];
          wrap_r      <= end_sum[64];
          zero_r      <= (in_length == 64'd0);
          type_r      <= in_region_type;
          idx_r       <= in_index;
          ptr_r       <= '0;
          fcount_r    <= CW'(1);
          pend_v_r    <= 1'b0;
          prev_pres_r <= 1'b0;
          ncnt_r      <= '0;
        end
        mrm_pkg::OP_PROBE: begin
          need_b_r <= ~|hit_b;
          need_e_r <= ~wrap_r & ~|hit_e;
        end
        mrm_pkg::OP_COUNT: begin
          if (!scan_end) begin
            if (ptr_r != '0 && rd_conv != prev_conv_r) fcount_r <= fcount_r + CW'(1);
            prev_conv_r <= rd_conv;
            ptr_r       <= ptr_r + CW'(1);
          end
        end
        mrm_pkg::OP_REWIND: begin
          ptr_r       <= '0;
          prev_pres_r <= 1'b0;
        end
        mrm_pkg::OP_SCAN: begin
          if (cand) begin
            if (pend_v_r) begin
              out_valid_r  <= 1'b1;
              out_status_r <= mrm_pkg::ST_OK;
              out_addr_r   <= 64'd0;
              out_type_r   <= mrm_pkg::RTYPE_UNDEF;
              out_count_r  <= 6'(fcount_r);
              out_page_r   <= pend_page_r;
              out_pages_r  <= pend_pages_r;
              out_last_r   <= 1'b0;
            end
            pend_v_r     <= 1'b1;
            pend_page_r  <= prev_first_r[51:0];
            pend_pages_r <= n_pages[52:0];
            ncnt_r       <= ncnt_r + RW'(1);
          end
          if (!scan_end) begin
            prev_pres_r  <= (rd_kind == mrm_pkg::RTYPE_PRESERVE);
            prev_first_r <= cur_first;
            ptr_r        <= ptr_r + CW'(1);
          end
        end
        mrm_pkg::OP_FLUSH: begin
          out_valid_r  <= 1'b1;
          out_status_r <= mrm_pkg::ST_OK;
          out_addr_r   <= 64'd0;
          out_type_r   <= mrm_pkg::RTYPE_UNDEF;
          out_count_r  <= 6'(fcount_r);
          out_page_r   <= pend_v_r ? pend_page_r : 52'd0;
          out_pages_r  <= pend_v_r ? pend_pages_r : 53'd0;
          out_last_r   <= 1'b1;
        end
        mrm_pkg::OP_READ: begin
          out_valid_r  <= 1'b1;
          out_status_r <= idx_ok ? mrm_pkg::ST_OK : mrm_pkg::ST_RANGE;
          out_addr_r   <= idx_ok ? rd_start : 64'd0;
          out_type_r   <= idx_ok ? rd_kind : mrm_pkg::RTYPE_UNDEF;
          out_count_r  <= 6'(count_r);
          out_page_r   <= 52'd0;
          out_pages_r  <= 53'd0;
          out_last_r   <= 1'b1;
        end
        mrm_pkg::OP_REPLY: begin
          out_valid_r  <= 1'b1;
          out_status_r <= cmd.status;
          out_addr_r   <= 64'd0;
          out_type_r   <= mrm_pkg::RTYPE_UNDEF;
          out_count_r  <= 6'(count_r);
          out_page_r   <= 52'd0;
          out_pages_r  <= 53'd0;
          out_last_r   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // full when the splits still needed would overflow the table
  assign stat.func       = func_r;
  assign stat.empty_len  = zero_r;
  assign stat.full       = (need_sum > (CW+1)'(TABLE_DEPTH));
  assign stat.need_base  = need_b_r;
  assign stat.need_end   = need_e_r;
  assign stat.merge_done = ~|dup;
  assign stat.scan_end   = scan_end;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_addr  = out_addr_r;
  assign out_entry_type  = out_type_r;
  assign out_entry_count = out_count_r;
  assign out_free_page   = out_page_r;
  assign out_free_pages  = out_pages_r;
  assign out_last        = out_last_r;

endmodule

// ===== hdl/memory_region_map.sv =====
// Top level of the physical memory region map: sequencer plus table datapath.
// Each transaction returns a single result, but unpreserve returns one per preserved region
// freeing pages, the final one with out_last set.
// One transaction at a time, the next taken once the sequencer is idle again; receiver cannot
// stall.
// Reset (synchronous, rst_n low): one entry at address 0, type undefined; no results pending.
module memory_region_map #(
  parameter int TABLE_DEPTH = mrm_pkg::TABLE_DEPTH_DEF,
  parameter int PAGE_SHIFT  = mrm_pkg::PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_base,
  input  logic [63:0] in_length,
  input  logic [3:0]  in_region_type,
  input  logic [4:0]  in_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_entry_addr,
  output logic [3:0]  out_entry_type,
  output logic [5:0]  out_entry_count,
  output logic [51:0] out_free_page,
  output logic [52:0] out_free_pages,
  output logic        out_last
);

  // command/status link between sequencer and datapath
  mrm_pkg::dp_cmd_t  cmd;
  mrm_pkg::dp_stat_t stat;

  mrm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // table, page arithmetic and result registers
  mrm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_base         (in_base),
    .in_length       (in_length),
    .in_region_type  (in_region_type),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_addr  (out_entry_addr),
    .out_entry_type  (out_entry_type),
    .out_entry_count (out_entry_count),
    .out_free_page   (out_free_page),
    .out_free_pages  (out_free_pages),
    .out_last        (out_last)
  );

endmodule
